FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent holds in this cycle, consequent in the next one.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/apsd_pkg.sv
// Shared constants and codes of the audio peak and silence detector.
package apsd_pkg;
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int NCH_W        = 4;
	localparam int WINDOW_DEPTH = 256;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = WIN_AW + 1;
	localparam int SAMPLE_BITS  = 16;
	localparam int LEVEL_W      = SAMPLE_BITS - 1;
	localparam int SQ_W         = 2 * LEVEL_W;
	localparam int SUM_W        = SQ_W + WIN_AW;
	localparam int TIME_BITS    = 40;
	localparam int RAM_W        = SQ_W + TIME_BITS;
	localparam int US_W         = 26;
	localparam int IVL_W        = 8;
	localparam int RCNT_W       = 9;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = US_W;

	localparam int DIV_STEPS    = SUM_W;
	localparam int SQRT_STEPS   = LEVEL_W;
	localparam int STEP_W       = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_BAR_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_INTERVAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_THRESH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_US      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd6;

	localparam logic [IVL_W-1:0]   RST_BAR_INTERVAL  = 8'd4;
	localparam logic [US_W-1:0]    RST_WINDOW_US     = 26'd5000000;
	localparam logic [LEVEL_W-1:0] RST_ALARM_THRESH  = 15'd655;
	localparam logic [US_W-1:0]    RST_REPEAT_US     = 26'd2000000;
	localparam logic [NCH_W-1:0]   RST_CHANNEL_COUNT = 4'd2;

	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;
endpackage

FILE: rtl/core/apsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/core/apsd_math.sv
// Iterative mean and square root unit: floor(sqrt(sum / count)).
module apsd_math (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [apsd_pkg::SUM_W-1:0]  sum,
	input  logic [apsd_pkg::CNT_W-1:0]  count,
	output logic                        done,
	output logic [apsd_pkg::LEVEL_W-1:0] root
);
	import apsd_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DIV  = 2'd1;
	localparam logic [1:0] PH_SQRT = 2'd2;

	logic [1:0]         phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [CNT_W-1:0]   dsr_q;
	logic [CNT_W-1:0]   rem_q;
	logic [SQ_W-1:0]    rad_q;
	logic [LEVEL_W+1:0] srem_q;
	logic [LEVEL_W-1:0] root_q;

	logic [CNT_W:0]     rsh;
	logic               dge;
	logic [LEVEL_W+3:0] ssh;
	logic [LEVEL_W+3:0] trial;
	logic               sge;

	always_comb begin
		rsh   = {rem_q, dvd_q[SUM_W-1]};
		dge   = rsh >= {1'b0, dsr_q};
		ssh   = {srem_q, rad_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		sge   = ssh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_DIV;
						step_q  <= '0;
					end
				end
				PH_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						phase_q <= PH_SQRT;
						step_q  <= '0;
					end
				end
				PH_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
						phase_q <= PH_IDLE;
						done    <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			dvd_q  <= sum;
			dsr_q  <= count;
			rem_q  <= '0;
			srem_q <= '0;
			root_q <= '0;
		end else if (phase_q == PH_DIV) begin
			rem_q <= dge ? CNT_W'(rsh - {1'b0, dsr_q}) : rsh[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], dge};
			// quotient never exceeds one stored square
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				rad_q <= {dvd_q[SQ_W-2:0], dge};
			end
		end else if (phase_q == PH_SQRT) begin
			srem_q <= sge ? (LEVEL_W + 2)'(ssh - trial) : ssh[LEVEL_W+1:0];
			root_q <= {root_q[LEVEL_W-2:0], sge};
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
		end
	end

	assign root = root_q;
endmodule

FILE: rtl/core/audio_peak_silence_detector_top.sv
// Top level of the audio peak meter with windowed RMS silence alarm.
// Samples that do not end a block are taken one per cycle while in_stall is
// low and only update the per-channel peaks. A block-end word starts a
// sequencer and holds in_stall high until it is done: with silence detection
// on it pushes the squared top peak into a 256-entry ring RAM, dropping the
// oldest entry first when the ring is full, evicts entries older than the
// window, and for a verdict runs the iterative mean and square root unit,
// division then square root, and emits a verdict report. Due peak reports
// then leave one per cycle while out_stall is low.
module audio_peak_silence_detector_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [apsd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [apsd_pkg::CH_W-1:0]          sample_channel,
	input  logic                               block_end,
	input  logic [apsd_pkg::TIME_BITS-1:0]     timestamp,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               report_kind,
	output logic [apsd_pkg::CH_W-1:0]          report_channel,
	output logic [apsd_pkg::LEVEL_W-1:0]       level,
	output logic                               alarm,
	output logic                               last,
	input  logic                               cfg_we,
	input  logic [apsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [apsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import apsd_pkg::*;
	`include "assert_macros.svh"

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_DROPRD = 4'd2;
	localparam logic [3:0] S_DROP   = 4'd3;
	localparam logic [3:0] S_PUSH   = 4'd4;
	localparam logic [3:0] S_EVRD   = 4'd5;
	localparam logic [3:0] S_EV     = 4'd6;
	localparam logic [3:0] S_VCHK   = 4'd7;
	localparam logic [3:0] S_MATH   = 4'd8;
	localparam logic [3:0] S_VOUT   = 4'd9;
	localparam logic [3:0] S_BAR    = 4'd10;
	localparam logic [3:0] S_PEAK   = 4'd11;
	localparam logic [3:0] S_CLR    = 4'd12;

	// configuration registers
	logic               bar_en_q;
	logic [IVL_W-1:0]   bar_ivl_q;
	logic               sil_en_q;
	logic [US_W-1:0]    window_us_q;
	logic [LEVEL_W-1:0] thresh_q;
	logic [US_W-1:0]    repeat_us_q;
	logic [NCH_W-1:0]   ch_count_q;

	logic [3:0]           state_q;
	logic [LEVEL_W-1:0]   peak_q [MAX_CHANNELS];
	logic [LEVEL_W-1:0]   top_q;
	logic [TIME_BITS-1:0] ts_q;
	logic [SQ_W-1:0]      sq_q;
	logic [TIME_BITS-1:0] limit_q;
	logic                 evict_en_q;
	logic [WIN_AW-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 started_q;
	logic [TIME_BITS-1:0] last_vt_q;
	logic [RCNT_W-1:0]    rcnt_q;
	logic [CH_W-1:0]      rep_ch_q;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [CH_W-1:0]      chan_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 alarm_q;
	logic                 last_q;

	logic [NCH_W-1:0]     n_eff;
	logic                 in_acc;
	logic                 hit;
	logic                 out_free;
	logic                 bar_due;
	logic                 verdict_due;
	logic [TIME_BITS:0]   vt_gap;
	logic                 ram_we;
	logic                 ram_re;
	logic [RAM_W-1:0]     ram_rdata;
	logic [SQ_W-1:0]      rd_level;
	logic [TIME_BITS-1:0] rd_time;
	logic                 math_start;
	logic                 math_done;
	logic [LEVEL_W-1:0]   math_root;

	always_comb begin
		n_eff    = (ch_count_q > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) : ch_count_q;
		in_stall = (state_q != S_IDLE);
		in_acc   = in_valid && !in_stall;
		hit      = ({1'b0, sample_channel} < n_eff) && !sample[SAMPLE_BITS-1]
		           && (sample[LEVEL_W-1:0] > peak_q[sample_channel]);
		out_free = !out_valid_q || !out_stall;
		bar_due  = bar_en_q && (n_eff != '0) && (rcnt_q > {1'b0, bar_ivl_q});
		vt_gap   = {1'b0, ts_q} - {1'b0, last_vt_q};
		verdict_due = started_q && (count_q != '0) && (ts_q > last_vt_q)
		              && (vt_gap > (TIME_BITS + 1)'(repeat_us_q));
		ram_we   = (state_q == S_PUSH);
		ram_re   = (state_q == S_DROPRD) || (state_q == S_EVRD);
		rd_level = ram_rdata[RAM_W-1 -: SQ_W];
		rd_time  = ram_rdata[TIME_BITS-1:0];
		math_start = (state_q == S_VCHK) && verdict_due;
	end

	// ring of squared peaks and their block times
	apsd_ram #(
		.WIDTH(RAM_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (WIN_AW'(head_q + count_q[WIN_AW-1:0])),
		.wdata ({sq_q, ts_q}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	apsd_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (math_start),
		.sum    (sum_q),
		.count  (count_q),
		.done   (math_done),
		.root   (math_root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_en_q    <= 1'b1;
			bar_ivl_q   <= RST_BAR_INTERVAL;
			sil_en_q    <= 1'b1;
			window_us_q <= RST_WINDOW_US;
			thresh_q    <= RST_ALARM_THRESH;
			repeat_us_q <= RST_REPEAT_US;
			ch_count_q  <= RST_CHANNEL_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAR_ENABLE:     bar_en_q    <= cfg_data[0];
				REG_BAR_INTERVAL:   bar_ivl_q   <= cfg_data[IVL_W-1:0];
				REG_SILENCE_ENABLE: sil_en_q    <= cfg_data[0];
				REG_WINDOW_US:      window_us_q <= cfg_data[US_W-1:0];
				REG_ALARM_THRESH:   thresh_q    <= cfg_data[LEVEL_W-1:0];
				REG_REPEAT_US:      repeat_us_q <= cfg_data[US_W-1:0];
				REG_CHANNEL_COUNT:  ch_count_q  <= cfg_data[NCH_W-1:0];
				default: ;
			endcase
		end
	end

	// block-end sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				peak_q[i] <= '0;
			end
			top_q     <= '0;
			head_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			started_q <= 1'b0;
			last_vt_q <= '0;
			rcnt_q    <= '0;
			rep_ch_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// peaks only rise, so the running top is the max peak
						if (hit) begin
							peak_q[sample_channel] <= sample[LEVEL_W-1:0];
							if (sample[LEVEL_W-1:0] > top_q) begin
								top_q <= sample[LEVEL_W-1:0];
							end
						end
						if (block_end) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					if (!sil_en_q) begin
						state_q <= S_BAR;
					end else if (count_q == CNT_W'(WINDOW_DEPTH)) begin
						state_q <= S_DROPRD;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_DROPRD: state_q <= S_DROP;
				S_DROP: begin
					// ring full: drop the oldest before storing
					sum_q   <= sum_q - SUM_W'(rd_level);
					head_q  <= head_q + 1'b1;
					count_q <= count_q - 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					sum_q   <= sum_q + SUM_W'(sq_q);
					count_q <= count_q + 1'b1;
					state_q <= S_EVRD;
				end
				S_EVRD: begin
					state_q <= (evict_en_q && count_q != '0) ? S_EV : S_VCHK;
				end
				S_EV: begin
					if (rd_time < limit_q) begin
						started_q <= 1'b1;
						sum_q     <= sum_q - SUM_W'(rd_level);
						head_q    <= head_q + 1'b1;
						count_q   <= count_q - 1'b1;
						state_q   <= S_EVRD;
					end else begin
						state_q <= S_VCHK;
					end
				end
				S_VCHK: begin
					if (verdict_due) begin
						last_vt_q <= ts_q;
						state_q   <= S_MATH;
					end else begin
						state_q <= S_BAR;
					end
				end
				S_MATH: begin
					if (math_done) begin
						state_q <= S_VOUT;
					end
				end
				S_VOUT: begin
					if (out_free) begin
						state_q <= S_BAR;
					end
				end
				S_BAR: begin
					if (bar_due) begin
						rcnt_q   <= '0;
						rep_ch_q <= '0;
						state_q  <= S_PEAK;
					end else begin
						if (bar_en_q && n_eff != '0) begin
							rcnt_q <= rcnt_q + 1'b1;
						end
						state_q <= S_CLR;
					end
				end
				S_PEAK: begin
					if (out_free) begin
						rep_ch_q <= rep_ch_q + 1'b1;
						if ({1'b0, rep_ch_q} == NCH_W'(n_eff - 1'b1)) begin
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					for (int i = 0; i < MAX_CHANNELS; i++) begin
						peak_q[i] <= '0;
					end
					top_q   <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// block-end operands: capture time, square the top peak, eviction limit
	always_ff @(posedge clk) begin
		if (in_acc && block_end) begin
			ts_q <= timestamp;
		end
		if (state_q == S_START) begin
			sq_q       <= top_q * top_q;
			limit_q    <= ts_q - TIME_BITS'(window_us_q);
			evict_en_q <= ts_q > TIME_BITS'(window_us_q);
		end
	end

	// output register: load a word when the slot is free, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_VOUT || state_q == S_PEAK) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VOUT && out_free) begin
			kind_q  <= KIND_VERDICT;
			chan_q  <= '0;
			level_q <= math_root;
			alarm_q <= math_root < thresh_q;
			last_q  <= !bar_due;
		end else if (state_q == S_PEAK && out_free) begin
			kind_q  <= KIND_PEAK;
			chan_q  <= rep_ch_q;
			level_q <= peak_q[rep_ch_q];
			alarm_q <= 1'b0;
			last_q  <= ({1'b0, rep_ch_q} == NCH_W'(n_eff - 1'b1));
		end
	end

	assign out_valid      = out_valid_q;
	assign report_kind    = kind_q;
	assign report_channel = chan_q;
	assign level          = level_q;
	assign alarm          = alarm_q;
	assign last           = last_q;

	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(WINDOW_DEPTH))
	`ASSERT_IMP(a_evict_nonempty, clk, arst_n, state_q == S_EV, count_q != '0)
	`ASSERT_NEXT(a_push_grows, clk, arst_n, state_q == S_PUSH,
		count_q == $past(count_q) + 1'b1)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q)
endmodule
